// ----- sv/cmv_pkg.sv -----
package cmv_pkg;

    localparam int MAX_SIZE_DEF = 256;
    localparam int RESET_SIZE   = 256;
    localparam int SIZE_W       = 9;
    localparam int ELEM_W       = 16;
    localparam int PROD_W       = 2 * ELEM_W;
    localparam int ACC_W        = 48;
    localparam int ROW_W        = 8;

    typedef struct packed {
        logic signed [ELEM_W-1:0] matrix_element;
        logic signed [ELEM_W-1:0] vector_element;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]        row_index;
        logic signed [ACC_W-1:0] row_sum;
        logic                    last;
    } t_out_item;

    // Index of the final row/column for a written size: zero acts as one,
    // anything above the supported depth is clamped.
    function automatic int unsigned eff_last(input logic [SIZE_W-1:0] size,
                                             input int unsigned max_size);
        int unsigned r;
        r = size - 1;
        if (size == '0) begin
            r = 0;
        end else if (int'(size) > int'(max_size)) begin
            r = max_size - 1;
        end
        return r;
    endfunction

endpackage

// ----- sv/cmv_ifs.sv -----
interface cmv_in_if;
    import cmv_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cmv_out_if;
    import cmv_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/column_streaming_matvec_top.sv -----
// Streaming matrix-vector product y = A*x. Feed the square matrix one element
// per item in column-major order (row index fastest), each item carrying the
// vector element of its column. The block takes one item every clock while
// its input is not held off. An accepted item first loads the input register,
// then the product and the accumulator read, and then it accumulates, writes
// back and, in the last column, loads the output register. During the last
// column every item releases one result: the finished row sum (Q18.30, 48
// bits, exact) with its row index, and last set on the final row. The input is
// held off only when a result waits unread in the output register and the
// item at the accumulate stage also carries a result. A write of matrix_size
// restarts at row 0 of column 0; write it only while no result is pending.
// Sizes of 0 act as 1, sizes above MAX_SIZE as MAX_SIZE.
module column_streaming_matvec_top #(
    parameter int MAX_SIZE = cmv_pkg::MAX_SIZE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cmv_pkg::SIZE_W-1:0] i_cfg_wdata,
    cmv_in_if.sink                     i_in,
    cmv_out_if.source                  o_out
);
    import cmv_pkg::*;

    // Row/column index width follows the accumulator depth.
    localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    // Accumulator storage, one entry per row; no reset.
    logic [ACC_W-1:0] r_acc_mem [MAX_SIZE];

    // Size and position counters.
    logic [AW-1:0] r_size_m1;
    logic [AW-1:0] r_row;
    logic [AW-1:0] r_col;

    // Stage 1: registered item and its position.
    logic                     r_v1;
    logic signed [ELEM_W-1:0] r_a1;
    logic signed [ELEM_W-1:0] r_x1;
    logic [AW-1:0]            r_row1;
    logic                     r_first1;
    logic                     r_emit1;
    logic                     r_last1;

    // Stage 2: product, accumulator read data and forward path.
    logic                     r_v2;
    logic signed [PROD_W-1:0] r_prod2;
    logic [ACC_W-1:0]         r_rd2;
    logic                     r_fwd2;
    logic [ACC_W-1:0]         r_fwd_val2;
    logic [AW-1:0]            r_row2;
    logic                     r_first2;
    logic                     r_emit2;
    logic                     r_last2;

    // Output register.
    logic             r_out_valid;
    logic [AW-1:0]    r_out_row;
    logic [ACC_W-1:0] r_out_sum;
    logic             r_out_last;

    logic             w_stall;
    logic             w_adv;
    logic             w_acc;
    logic [ACC_W-1:0] w_prod_ext;
    logic [ACC_W-1:0] w_base;
    logic [ACC_W-1:0] w_sum;
    logic [AW-1:0]    n_row;
    logic [AW-1:0]    n_col;

    // Freeze the whole pipe only when a result cannot leave the add stage.
    assign w_stall = r_out_valid && !o_out.ready && r_v2 && r_emit2;
    assign w_adv   = !w_stall;
    assign w_acc   = i_in.valid && w_adv;

    assign i_in.ready = w_adv;

    // Advance row fastest, then column; wrap both at the end of the matrix.
    always_comb begin
        n_row = r_row + AW'(1);
        n_col = r_col;
        if (r_row == r_size_m1) begin
            n_row = '0;
            n_col = (r_col == r_size_m1) ? '0 : r_col + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_m1 <= AW'(eff_last(SIZE_W'(RESET_SIZE), MAX_SIZE));
            r_row     <= '0;
            r_col     <= '0;
        end else if (i_cfg_we) begin
            r_size_m1 <= AW'(eff_last(i_cfg_wdata, MAX_SIZE));
            r_row     <= '0;
            r_col     <= '0;
        end else if (w_acc) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // Valid bits travel with the data and hold during a stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
        end
    end

    // Stage 1 payload: capture the item and tag its place in the matrix.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a1     <= i_in.data.matrix_element;
            r_x1     <= i_in.data.vector_element;
            r_row1   <= r_row;
            r_first1 <= (r_col == '0);
            r_emit1  <= (r_col == r_size_m1);
            r_last1  <= (r_row == r_size_m1);
        end
    end

    // Stage 2 payload: multiply; forward the sum being written this cycle
    // when it targets the same row (only small sizes revisit a row so soon).
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod2    <= r_a1 * r_x1;
            r_fwd2     <= r_v2 && (r_row2 == r_row1);
            r_fwd_val2 <= w_sum;
            r_row2     <= r_row1;
            r_first2   <= r_first1;
            r_emit2    <= r_emit1;
            r_last2    <= r_last1;
        end
    end

    assign w_prod_ext = {{(ACC_W - PROD_W){r_prod2[PROD_W-1]}}, r_prod2};
    assign w_base     = r_fwd2 ? r_fwd_val2 : r_rd2;
    assign w_sum      = r_first2 ? w_prod_ext : w_base + w_prod_ext;

    // Accumulator memory: read for stage 1, write back from stage 2.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rd2 <= r_acc_mem[r_row1];
            if (r_v2) begin
                r_acc_mem[r_row2] <= w_sum;
            end
        end
    end

    // Output register: load a finished row, drop it once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_v2 && r_emit2) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_v2 && r_emit2) begin
            r_out_row  <= r_row2;
            r_out_sum  <= w_sum;
            r_out_last <= r_last2;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.data.row_index = ROW_W'(r_out_row);
    assign o_out.data.row_sum   = r_out_sum;
    assign o_out.data.last      = r_out_last;

endmodule

// ----- sv/cmv_checker.sv -----
module cmv_checker #(
    parameter int MAX_SIZE = cmv_pkg::MAX_SIZE_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_cfg_we,
    input logic [cmv_pkg::SIZE_W-1:0] i_cfg_wdata,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input cmv_pkg::t_out_item         i_out_data
);
    import cmv_pkg::*;

    logic [31:0] r_last_idx;

    // Track the final row index from the size writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx <= eff_last(SIZE_W'(RESET_SIZE), MAX_SIZE);
        end else if (i_cfg_we) begin
            r_last_idx <= eff_last(i_cfg_wdata, MAX_SIZE);
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed or dropped");

    a_ready_only_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input held off without output backpressure");

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.last |-> 32'(i_out_data.row_index) == (r_last_idx & 32'hFF))
        else $error("last flag on a row other than the final one");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> 32'(i_out_data.row_index) <= r_last_idx)
        else $error("row index beyond matrix size");

endmodule

bind column_streaming_matvec_top cmv_checker #(.MAX_SIZE(MAX_SIZE)) u_cmv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_wdata (i_cfg_wdata),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
